/* rtl/core/rational_arithmetic_unit_assert.svh */
// assertion macros for the rational arithmetic unit
// depends on nothing; included by modules that assert
`ifndef RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`define RATIONAL_ARITHMETIC_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define RAU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define RAU_ASSERT_IMP(label, clk, rst, ante, cons)
`define RAU_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/rau_pkg.sv */
// types and constants for the rational arithmetic unit
// no dependencies
package rau_pkg;
   localparam int RES_W = 33;
   localparam int VW    = 16;
   typedef enum logic [1:0] {OP_ADD = 2'd0, OP_SUB = 2'd1, OP_MUL = 2'd2, OP_DIV = 2'd3}
      opcode_type;
   typedef struct packed {
      opcode_type      opcode;
      logic [VW-1:0]   a_num;
      logic [VW-1:0]   a_den;
      logic [VW-1:0]   b_num;
      logic [VW-1:0]   b_den;
   } req_type;
   typedef struct packed {
      logic [RES_W-1:0] res_num;
      logic [RES_W-1:0] res_den;
      logic             status;
   } rsp_type;
endpackage

/* rtl/core/rau_divider.sv */
// shared restoring divider, one quotient bit per cycle
// depends on rau_pkg
module rau_divider #(
   parameter int W = 32
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  logic [W-1:0] dividend,
   input  logic [W-1:0] divisor,
   output logic         done,
   output logic [W-1:0] quot,
   output logic [W-1:0] rem
);
   import rau_pkg::*;
   localparam int CW = $clog2(W + 1);
   logic [W-1:0]  q_ff, q_in, r_ff, r_in, d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          run_ff, run_in, done_ff, done_in;
   logic [W:0]    trial;
   always_comb begin
      q_in = q_ff; r_in = r_ff; d_in = d_ff; cnt_in = cnt_ff;
      run_in = run_ff; done_in = 1'b0;
      trial = {r_ff, q_ff[W-1]} - {1'b0, d_ff};
      if (go) begin
         q_in = dividend; r_in = '0; d_in = divisor;
         cnt_in = CW'(W); run_in = 1'b1;
      end else if (run_ff) begin
         if (!trial[W]) begin
            r_in = trial[W-1:0];
            q_in = {q_ff[W-2:0], 1'b1};
         end else begin
            r_in = {r_ff[W-2:0], q_ff[W-1]};
            q_in = {q_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0; done_in = 1'b1;
         end
      end
   end
   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; d_ff <= d_in; cnt_ff <= cnt_in;
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         run_ff <= run_in; done_ff <= done_in;
      end
   end
   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = r_ff;
endmodule

/* rtl/core/rational_arithmetic_unit.sv */
// Rational arithmetic unit: add, subtract, multiply or divide two fractions. The
// result is not reduced, and a status bit flags add or subtract with exactly one zero denominator.
// A start beat is taken only while busy is low. Busy stays high until the result
// beat. That beat is on rsp_data for the single cycle that rsp_valid is high, and
// the receiver cannot stall it. Busy is already low in that cycle.
// After the start beat, the result comes:
// - straight from decode for add/subtract with equal denominators or one zero denominator
// - for multiply/divide, after two passes of the shared multiplier
// - for any other add/subtract, after Euclid's gcd on one shared restoring divider.
//   Each division is a launch, 32 quotient bits and a step to hand the result back.
//   Three more divisions follow for the lcm and the two scale factors. The gcd is
//   skipped when either denominator is negative; otherwise it takes at most 22
//   divisions.
// depends on rau_pkg, rau_divider, rational_arithmetic_unit_assert.svh
`include "rational_arithmetic_unit_assert.svh"
module rational_arithmetic_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rau_pkg::req_type req_data,
   output logic             rsp_valid,
   output rau_pkg::rsp_type rsp_data
);
   import rau_pkg::*;
   localparam int VALUE_WIDTH = VW;
   localparam int DW = 2 * VALUE_WIDTH;
   typedef enum logic [3:0] {S_IDLE, S_DECODE, S_MUL1, S_MUL2, S_GCD, S_GCDW, S_LCM,
      S_LCMW, S_QA, S_QAW, S_QB, S_QBW, S_SCALE, S_COMB, S_SUM, S_OUT} state_type;
   state_type state_ff;
   opcode_type op_ff;
   logic signed [VALUE_WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff;
   logic [DW-1:0] x_ff, y_ff, l_ff;
   logic [VALUE_WIDTH-1:0] qa_ff, qb_ff;
   logic signed [DW+1:0] p1_ff, p2_ff;
   logic [RES_W-1:0] rn_ff, rd_ff;
   logic          st_ff, vld_ff, go;
   logic [DW-1:0] dvd, dvs, quo, rem;
   logic          ddone;
   logic [VALUE_WIDTH-1:0] ua, ub;
   logic          pos_den;
   logic signed [VALUE_WIDTH:0] mul_a, mul_b;
   logic signed [DW+1:0] mul_p, ta, tb, term_sum;
   assign ua = ad_ff[VALUE_WIDTH-1] ? VALUE_WIDTH'(-ad_ff) : ad_ff;
   assign ub = bd_ff[VALUE_WIDTH-1] ? VALUE_WIDTH'(-bd_ff) : bd_ff;
   assign pos_den = !ad_ff[VALUE_WIDTH-1] && !bd_ff[VALUE_WIDTH-1];

   rau_divider #(.W(DW)) u_div (.clock(clock), .reset(reset), .go(go),
      .dividend(dvd), .divisor(dvs), .done(ddone), .quot(quo), .rem(rem));

   // one shared multiplier, operands picked by state
   assign mul_p = mul_a * mul_b;
   // scaled terms are negated when their denominator is negative
   assign ta = ad_ff[VALUE_WIDTH-1] ? -p1_ff : p1_ff;
   assign tb = bd_ff[VALUE_WIDTH-1] ? -p2_ff : p2_ff;
   assign term_sum = (op_ff == OP_SUB) ? ta - tb : ta + tb;

   always_comb begin
      go = 1'b0; dvd = x_ff; dvs = y_ff;
      mul_a = {an_ff[VALUE_WIDTH-1], an_ff};
      mul_b = {bn_ff[VALUE_WIDTH-1], bn_ff};
      case (state_ff)
         S_DECODE: begin
            if (op_ff == OP_MUL || op_ff == OP_DIV) begin
               mul_b = (op_ff == OP_MUL) ? {bn_ff[VALUE_WIDTH-1], bn_ff}
                                         : {bd_ff[VALUE_WIDTH-1], bd_ff};
            end else begin
               mul_a = {1'b0, ua};
               mul_b = {1'b0, ub};
            end
         end
         S_MUL1: begin
            mul_a = {ad_ff[VALUE_WIDTH-1], ad_ff};
            mul_b = (op_ff == OP_MUL) ? {bd_ff[VALUE_WIDTH-1], bd_ff}
                                      : {bn_ff[VALUE_WIDTH-1], bn_ff};
         end
         S_SCALE: mul_b = {1'b0, qa_ff};
         S_COMB: begin
            mul_a = {bn_ff[VALUE_WIDTH-1], bn_ff};
            mul_b = {1'b0, qb_ff};
         end
         S_GCD: go = 1'b1;
         S_LCM: begin go = 1'b1; dvd = p1_ff[DW-1:0]; dvs = x_ff; end
         S_QA: begin go = 1'b1; dvd = l_ff; dvs = DW'(ua); end
         S_QB: begin go = 1'b1; dvd = l_ff; dvs = DW'(ub); end
         default: go = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; vld_ff <= 1'b0;
      end else begin
         vld_ff <= (state_ff == S_OUT);
         case (state_ff)
            S_IDLE: if (start) begin
               op_ff <= req_data.opcode;
               an_ff <= VALUE_WIDTH'(req_data.a_num); ad_ff <= VALUE_WIDTH'(req_data.a_den);
               bn_ff <= VALUE_WIDTH'(req_data.b_num); bd_ff <= VALUE_WIDTH'(req_data.b_den);
               state_ff <= S_DECODE;
            end
            S_DECODE: begin
               if (op_ff == OP_MUL || op_ff == OP_DIV) begin
                  st_ff <= 1'b0;
                  p1_ff <= mul_p;
                  state_ff <= S_MUL1;
               end else if (ad_ff == bd_ff) begin
                  st_ff <= 1'b0;
                  rn_ff <= RES_W'(op_ff == OP_SUB ? 64'($signed(an_ff)) - 64'($signed(bn_ff))
                                                  : 64'($signed(an_ff)) + 64'($signed(bn_ff)));
                  rd_ff <= RES_W'(64'($signed(ad_ff)));
                  state_ff <= S_OUT;
               end else if (ad_ff == '0 || bd_ff == '0) begin
                  st_ff <= 1'b1; rn_ff <= '0; rd_ff <= '0;
                  state_ff <= S_OUT;
               end else begin
                  st_ff <= 1'b0;
                  p1_ff <= mul_p;
                  // gcd only for two positive denominators, else divide by one
                  x_ff <= pos_den ? DW'(ua) : DW'(1);
                  y_ff <= DW'(ub);
                  state_ff <= pos_den ? S_GCD : S_LCM;
               end
            end
            S_MUL1: begin
               rn_ff <= p1_ff[RES_W-1:0];
               p2_ff <= mul_p;
               state_ff <= S_MUL2;
            end
            S_MUL2: begin rd_ff <= p2_ff[RES_W-1:0]; state_ff <= S_OUT; end
            S_GCD: state_ff <= S_GCDW;
            S_GCDW: if (ddone) begin
               x_ff <= y_ff; y_ff <= rem;
               state_ff <= (rem == '0) ? S_LCM : S_GCD;
            end
            S_LCM: state_ff <= S_LCMW;
            S_LCMW: if (ddone) begin l_ff <= quo; state_ff <= S_QA; end
            S_QA: state_ff <= S_QAW;
            S_QAW: if (ddone) begin qa_ff <= quo[VALUE_WIDTH-1:0]; state_ff <= S_QB; end
            S_QB: state_ff <= S_QBW;
            S_QBW: if (ddone) begin qb_ff <= quo[VALUE_WIDTH-1:0]; state_ff <= S_SCALE; end
            S_SCALE: begin p1_ff <= mul_p; state_ff <= S_COMB; end
            S_COMB: begin
               p2_ff <= mul_p;
               rd_ff <= RES_W'(l_ff);
               state_ff <= S_SUM;
            end
            S_SUM: begin rn_ff <= term_sum[RES_W-1:0]; state_ff <= S_OUT; end
            S_OUT: state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_data = '{res_num: rn_ff, res_den: rd_ff, status: st_ff};

   `RAU_ASSERT_NXT(a_start_busy, clock, reset, start && !busy, busy)
   `RAU_ASSERT_IMP(a_vld_idle, clock, reset, rsp_valid, !busy)
   `RAU_ASSERT_IMP(a_status_zero, clock, reset, rsp_valid && rsp_data.status, rsp_data.res_den == '0)
endmodule
